// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, ignored while reset is low
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    `ASSERT_CLK(lbl, clk, rst_n, !(cond))

`endif

// ===== hw/rtl/tlbpt_pkg.sv =====
`default_nettype none

package tlbpt_pkg;

    // Geometry
    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_COUNT  = 256;
    localparam int PAGE_BYTES  = 256;

    // Field widths
    localparam int ADDR_W   = 16;
    localparam int PAGE_W   = 8;
    localparam int OFFSET_W = 8;
    localparam int FRAME_W  = 8;
    localparam int FREE_W   = 9;
    localparam int COUNT_W  = 32;

    localparam int TLB_IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int PT_IDX_W  = $clog2(PAGE_COUNT);

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 104;

    typedef enum logic {
        S_IDLE,
        S_LOOKUP
    } tlbpt_state_t;

    // One result beat, lowest field last
    typedef struct packed {
        logic [COUNT_W-1:0] fault_count;
        logic [COUNT_W-1:0] hit_count;
        logic [PAGE_W-1:0]  load_page;
        logic               page_fault;
        logic               tlb_hit;
        logic [FRAME_W-1:0] frame_number;
        logic [ADDR_W-1:0]  physical_address;
    } tlbpt_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlb_page_table_translator.sv =====
// Logical to physical address translator with a FIFO-replaced TLB and a
// demand-paged page table.
// Input channel s_axis: one beat per address, s_axis_tdata[15:0] holds the
// logical address (page in bits 15..8, offset in bits 7..0).
// Output channel m_axis: one beat per input beat, in order. m_axis_tdata,
// from bit 0 up: physical_address[15:0], frame_number[23:16], tlb_hit[24],
// page_fault[25], load_page[33:26], hit_count[65:34], fault_count[97:66],
// zero fill to bit 103.
// Timing: an address is taken in the idle step while the page-table memory
// is read into a register; in the lookup step that follows, the TLB is
// searched, the tables are updated and the result register is loaded once
// it is free. A new address is taken as soon as the previous result is
// registered, while that result may still wait on m_axis_tready.
// If the receiver stalls with a result pending, the next item waits in the
// lookup step and s_axis_tready stays low.
// Reset (aresetn low, synchronous) invalidates all TLB and page-table
// entries, clears the FIFO pointer, free-frame count and both counters, and
// drops any pending result. Page-table frame storage needs no clearing.
`default_nettype none
`include "assert_macros.svh"

module tlb_page_table_translator
    import tlbpt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // logical_address[15:0]
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // physical_address[15:0], frame_number[23:16], tlb_hit[24],
    // page_fault[25], load_page[33:26], hit_count[65:34], fault_count[97:66]
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    tlbpt_state_t state_reg, state_next;

    // Page table: frame storage in memory, valid bits in flops
    logic [FRAME_W-1:0]    pt_mem [PAGE_COUNT];
    logic [FRAME_W-1:0]    pt_rdata_reg;
    logic [PAGE_COUNT-1:0] pt_valid_reg;

    // TLB
    logic [PAGE_W-1:0]      tlb_tag_reg   [TLB_ENTRIES];
    logic [FRAME_W-1:0]     tlb_frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] tlb_valid_reg;
    logic [TLB_IDX_W-1:0]   fifo_ptr_reg, fifo_ptr_next;

    logic [FREE_W-1:0]  next_free_reg, next_free_next;
    logic [COUNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic [COUNT_W-1:0] fault_cnt_reg, fault_cnt_next;

    // Item under lookup
    logic [PAGE_W-1:0]   page_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [PT_IDX_W-1:0] pt_idx_reg;

    logic          m_valid_reg, m_valid_next;
    tlbpt_result_t m_data_reg, m_data_next;

    logic               s_accept;
    logic               out_load;
    logic               tlb_hit;
    logic [FRAME_W-1:0] tlb_frame;
    logic               pt_fault;
    logic [FRAME_W-1:0] frame_sel;
    logic [PT_IDX_W-1:0] s_pt_idx;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign s_pt_idx = PT_IDX_W'(s_axis_tdata[ADDR_W-1 -: PAGE_W] % PAGE_COUNT);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_axis_tvalid) state_next = S_LOOKUP;
            S_LOOKUP: if (!m_valid_reg || m_axis_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            S_IDLE:   s_axis_tready = 1'b1;
            S_LOOKUP: out_load = !m_valid_reg || m_axis_tready;
            default:  s_axis_tready = 1'b0;
        endcase
    end

    // Search the TLB, highest matching index wins
    always_comb begin
        tlb_hit   = 1'b0;
        tlb_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (tlb_valid_reg[i] && tlb_tag_reg[i] == page_reg) begin
                tlb_hit   = 1'b1;
                tlb_frame = tlb_frame_reg[i];
            end
        end
    end

    // Pick the frame: TLB, freshly allocated, or page-table entry
    assign pt_fault  = !tlb_hit && !pt_valid_reg[pt_idx_reg];
    assign frame_sel = tlb_hit  ? tlb_frame :
                       pt_fault ? next_free_reg[FRAME_W-1:0] : pt_rdata_reg;

    // Counters, pointers and the result beat
    always_comb begin
        fifo_ptr_next  = fifo_ptr_reg;
        next_free_next = next_free_reg;
        hit_cnt_next   = hit_cnt_reg;
        fault_cnt_next = fault_cnt_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (m_axis_tready) m_valid_next = 1'b0;

        if (out_load) begin
            if (tlb_hit) begin
                if (hit_cnt_reg != '1) hit_cnt_next = hit_cnt_reg + COUNT_W'(1);
            end else begin
                fifo_ptr_next = (fifo_ptr_reg == TLB_IDX_W'(TLB_ENTRIES - 1)) ?
                                '0 : fifo_ptr_reg + TLB_IDX_W'(1);
                if (pt_fault) begin
                    next_free_next = next_free_reg + FREE_W'(1);
                    if (fault_cnt_reg != '1) fault_cnt_next = fault_cnt_reg + COUNT_W'(1);
                end
            end
            m_valid_next                 = 1'b1;
            m_data_next.physical_address =
                ADDR_W'(32'(frame_sel) * PAGE_BYTES + 32'(offset_reg));
            m_data_next.frame_number     = frame_sel;
            m_data_next.tlb_hit          = tlb_hit;
            m_data_next.page_fault       = pt_fault;
            m_data_next.load_page        = pt_fault ? page_reg : '0;
            m_data_next.hit_count        = hit_cnt_next;
            m_data_next.fault_count      = fault_cnt_next;
        end
    end

    // Page-table memory: read on accept, write on fault
    always_ff @(posedge aclk) begin
        if (s_accept) pt_rdata_reg <= pt_mem[s_pt_idx];
        if (out_load && pt_fault) pt_mem[pt_idx_reg] <= next_free_reg[FRAME_W-1:0];
    end

    // Capture the accepted address
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            page_reg   <= s_axis_tdata[ADDR_W-1 -: PAGE_W];
            offset_reg <= s_axis_tdata[OFFSET_W-1:0];
            pt_idx_reg <= s_pt_idx;
        end
    end

    // Fill the TLB slot at the FIFO pointer on a miss; register the result beat
    always_ff @(posedge aclk) begin
        if (out_load && !tlb_hit) begin
            tlb_tag_reg[fifo_ptr_reg]   <= page_reg;
            tlb_frame_reg[fifo_ptr_reg] <= frame_sel;
        end
        m_data_reg <= m_data_next;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            tlb_valid_reg <= '0;
            pt_valid_reg  <= '0;
            fifo_ptr_reg  <= '0;
            next_free_reg <= '0;
            hit_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fifo_ptr_reg  <= fifo_ptr_next;
            next_free_reg <= next_free_next;
            hit_cnt_reg   <= hit_cnt_next;
            fault_cnt_reg <= fault_cnt_next;
            m_valid_reg   <= m_valid_next;
            if (out_load && !tlb_hit) tlb_valid_reg[fifo_ptr_reg] <= 1'b1;
            if (out_load && pt_fault) pt_valid_reg[pt_idx_reg] <= 1'b1;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(m_data_reg);

    // Checks
    `ASSERT_NEVER(a_hit_and_fault, aclk, aresetn,
        m_valid_reg && m_data_reg.tlb_hit && m_data_reg.page_fault)
    `ASSERT_CLK(a_accept_to_lookup, aclk, aresetn,
        s_accept |=> state_reg == S_LOOKUP)
    `ASSERT_CLK(a_fault_allocates, aclk, aresetn,
        (out_load && pt_fault) |=> next_free_reg == FREE_W'($past(next_free_reg) + 1'b1))
    `ASSERT_CLK(a_hit_count_monotonic, aclk, aresetn,
        out_load |=> hit_cnt_reg >= $past(hit_cnt_reg))

endmodule

`default_nettype wire

// ===== bench/tlb_page_table_translator_tb.sv =====
`timescale 1ns / 1ps

module tlb_page_table_translator_tb;
    import tlbpt_pkg::*;

    localparam int RESULT_W       = $bits(tlbpt_result_t);
    localparam int RANDOM_ITEMS   = 1450;
    localparam int HOLDOFF_AFTER  = 400;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    // Receiver ready patterns
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_MOSTLY,
        RX_HALF,
        RX_SPARSE
    } rx_pattern_t;

    // One directed row; res is only meaningful when fixed is set
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              fixed;
        tlbpt_result_t     res;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 23;
    // res fields: fault_count, hit_count, load_page, page_fault, tlb_hit, frame, physical
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{16'h0000, 1'b1, '{32'd1, 32'd0, 8'h00, 1'b1, 1'b0, 8'h00, 16'h0000}},
        '{16'hFFFF, 1'b1, '{32'd2, 32'd0, 8'hFF, 1'b1, 1'b0, 8'h01, 16'h01FF}},
        '{16'h00AB, 1'b1, '{32'd2, 32'd1, 8'h00, 1'b0, 1'b1, 8'h00, 16'h00AB}},
        '{16'hFF00, 1'b1, '{32'd2, 32'd2, 8'h00, 1'b0, 1'b1, 8'h01, 16'h0100}},
        // fill the remaining TLB slots with fresh pages
        '{16'h0134, 1'b0, '0}, '{16'h02FF, 1'b0, '0}, '{16'h0300, 1'b0, '0},
        '{16'h0455, 1'b0, '0}, '{16'h05AA, 1'b0, '0}, '{16'h0601, 1'b0, '0},
        '{16'h07FE, 1'b0, '0}, '{16'h0880, 1'b0, '0}, '{16'h097F, 1'b0, '0},
        '{16'h0A10, 1'b0, '0}, '{16'h0BEF, 1'b0, '0}, '{16'h0C20, 1'b0, '0},
        '{16'h0DDF, 1'b0, '0}, '{16'h0E00, 1'b0, '0},
        // wrap the FIFO pointer, evicting page 0
        '{16'h8012, 1'b0, '0},
        // evicted pages come back from the page table without a fault, while page 80 still hits
        '{16'h0042, 1'b0, '0}, '{16'hFF80, 1'b0, '0},
        '{16'h8001, 1'b0, '0}, '{16'h01FF, 1'b0, '0}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // logical_address[15:0]
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // physical_address[15:0], frame_number[23:16], tlb_hit[24],
    // page_fault[25], load_page[33:26], hit_count[65:34], fault_count[97:66]
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // Shadow translation state
    logic [PAGE_W-1:0]    tlb_tag    [TLB_ENTRIES] = '{default: '0};
    logic [FRAME_W-1:0]   tlb_frame  [TLB_ENTRIES] = '{default: '0};
    logic                 tlb_valid  [TLB_ENTRIES] = '{default: 1'b0};
    logic [FRAME_W-1:0]   pt_frame   [PAGE_COUNT]  = '{default: '0};
    logic                 pt_valid   [PAGE_COUNT]  = '{default: 1'b0};
    int                   fifo_ptr   = 0;
    logic [FREE_W-1:0]    free_frame = '0;
    logic [COUNT_W-1:0]   hit_total  = '0;
    logic [COUNT_W-1:0]   fault_total = '0;

    tlbpt_result_t        pending_translations [$];
    logic [PAGE_W-1:0]    resident_pages [$];
    logic [PAGE_W-1:0]    recent_pages [$];

    int                   error_count = 0;
    int                   inputs_accepted = 0;
    int                   refill_total = 0;
    int                   burst_left = 0;
    int                   idle_cycles = 0;
    int                   holdoff_seen = 0;
    tlbpt_result_t        observed;
    tlbpt_result_t        predicted;

    tlb_page_table_translator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Translate one address and advance the shadow TLB and page table
    function automatic tlbpt_result_t translate_address(input logic [ADDR_W-1:0] addr);
        logic [PAGE_W-1:0]   page;
        logic [OFFSET_W-1:0] offset;
        logic [FRAME_W-1:0]  frame;
        logic [PT_IDX_W-1:0] idx;
        logic [31:0]         phys;
        tlbpt_result_t       res;
        int                  i;
        page   = addr[ADDR_W-1:OFFSET_W];
        offset = addr[OFFSET_W-1:0];
        res    = '0;
        frame  = '0;
        // search every entry; the highest matching index wins
        for (i = 0; i < TLB_ENTRIES; i++) begin
            if (tlb_valid[i] && tlb_tag[i] == page) begin
                frame       = tlb_frame[i];
                res.tlb_hit = 1'b1;
            end
        end
        if (res.tlb_hit) begin
            if (hit_total != '1)
                hit_total = hit_total + 1'b1;
        end else begin
            idx = PT_IDX_W'(page % PAGE_COUNT);
            // allocate the next free frame on a page fault
            if (!pt_valid[idx]) begin
                pt_frame[idx]  = free_frame[FRAME_W-1:0];
                pt_valid[idx]  = 1'b1;
                free_frame     = free_frame + 1'b1;
                if (fault_total != '1)
                    fault_total = fault_total + 1'b1;
                res.page_fault = 1'b1;
                res.load_page  = page;
                resident_pages.push_back(page);
            end else begin
                refill_total++;
            end
            frame               = pt_frame[idx];
            tlb_tag[fifo_ptr]   = page;
            tlb_frame[fifo_ptr] = frame;
            tlb_valid[fifo_ptr] = 1'b1;
            fifo_ptr            = (fifo_ptr + 1) % TLB_ENTRIES;
        end
        phys                 = frame * PAGE_BYTES + offset;
        res.physical_address = phys[ADDR_W-1:0];
        res.frame_number     = frame;
        res.hit_count        = hit_total;
        res.fault_count      = fault_total;
        return res;
    endfunction

    // Offer one address in the current burst, wait for the beat, queue the expected result
    task automatic send_address(input logic [ADDR_W-1:0] addr, input logic fixed,
                                input tlbpt_result_t literal_res);
        int            gap;
        tlbpt_result_t want;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= addr;
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        inputs_accepted++;
        want = translate_address(addr);
        pending_translations.push_back(fixed ? literal_res : want);
        recent_pages.push_back(addr[ADDR_W-1:OFFSET_W]);
        if (recent_pages.size() > 24)
            void'(recent_pages.pop_front());
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Stimulus: directed table, then random addresses
    initial begin
        logic [PAGE_W-1:0]   page;
        logic [OFFSET_W-1:0] offset;
        int                  pick;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_address(DIRECTED[r].addr, DIRECTED[r].fixed, DIRECTED[r].res);

        // mostly recently used and resident pages, some fresh ones and extremes
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
            else if (pick < 70)
                page = resident_pages[$urandom_range(0, resident_pages.size() - 1)];
            else if (pick < 92)
                page = PAGE_W'($urandom_range(0, 255));
            else
                page = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
            if ($urandom_range(0, 9) == 0)
                offset = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
            else
                offset = OFFSET_W'($urandom_range(0, 255));
            send_address({page, offset}, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        // drain, then give the block time to emit anything stray
        while (pending_translations.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Translated %0d addresses: %0d TLB hits, %0d page faults, %0d page-table refills",
                 inputs_accepted, hit_total, fault_total, refill_total);
        $display("%0d of %0d pages mapped; receiver held off %0d cycles with input offered",
                 resident_pages.size(), PAGE_COUNT, holdoff_seen);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random ready patterns plus one long hold-off
    initial begin
        rx_pattern_t pattern;
        int          pattern_left;
        int          holdoff_left;
        m_axis_tready = 1'b0;
        pattern_left  = 0;
        holdoff_left  = 0;
        pattern       = RX_STREAM;
        forever begin
            @(posedge aclk);
            if (holdoff_left > 0) begin
                m_axis_tready <= 1'b0;
                holdoff_left--;
                holdoff_seen++;
            end else if (holdoff_seen == 0 && inputs_accepted >= HOLDOFF_AFTER) begin
                m_axis_tready <= 1'b0;
                holdoff_left = HOLDOFF_CYCLES - 1;
                holdoff_seen = 1;
            end else begin
                if (pattern_left == 0) begin
                    pattern      = rx_pattern_t'($urandom_range(0, 3));
                    pattern_left = $urandom_range(20, 120);
                end
                pattern_left--;
                case (pattern)
                    RX_STREAM: m_axis_tready <= 1'b1;
                    RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 9) != 0);
                    RX_HALF:   m_axis_tready <= ($urandom_range(0, 1) != 0);
                    default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Compare each result beat with the oldest expected translation
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            observed = tlbpt_result_t'(m_axis_tdata[RESULT_W-1:0]);
            if (pending_translations.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none actual %h",
                         $time, m_axis_tdata);
                error_count++;
            end else begin
                predicted = pending_translations.pop_front();
                check_field("physical_address", 32'(predicted.physical_address),
                            32'(observed.physical_address));
                check_field("frame_number", 32'(predicted.frame_number),
                            32'(observed.frame_number));
                check_field("tlb_hit", 32'(predicted.tlb_hit), 32'(observed.tlb_hit));
                check_field("page_fault", 32'(predicted.page_fault), 32'(observed.page_fault));
                check_field("load_page", 32'(predicted.load_page), 32'(observed.load_page));
                check_field("hit_count", predicted.hit_count, observed.hit_count);
                check_field("fault_count", predicted.fault_count, observed.fault_count);
                check_field("zero fill", 32'd0, 32'(m_axis_tdata[M_TDATA_W-1:RESULT_W]));
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== tlb_page_table_translator.f =====
+incdir+hw/rtl
hw/rtl/tlbpt_pkg.sv
hw/rtl/tlb_page_table_translator.sv
bench/tlb_page_table_translator_tb.sv
